[hdl/pbcd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pushbuffer command decoder package
// Shared constants, command classes and the queued request type.
// ----------------------------------------------------------------------------
package pbcd_pkg;

  // Depth of the queue between classify front and execute back
  localparam int QueueDepthDefault = 2;

  // Sticky error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_PROTECTION = 3'd1;
  localparam logic [2:0] ERR_CALL       = 3'd2;
  localparam logic [2:0] ERR_RETURN     = 3'd3;
  localparam logic [2:0] ERR_RESERVED   = 3'd4;

  // Command classes found by the front
  localparam logic [2:0] CLS_OLD_JUMP = 3'd0;
  localparam logic [2:0] CLS_JUMP     = 3'd1;
  localparam logic [2:0] CLS_CALL     = 3'd2;
  localparam logic [2:0] CLS_RETURN   = 3'd3;
  localparam logic [2:0] CLS_INC_HDR  = 3'd4;
  localparam logic [2:0] CLS_NINC_HDR = 3'd5;
  localparam logic [2:0] CLS_RESERVED = 3'd6;

  // Command word patterns
  localparam logic [31:0] OLD_JUMP_MASK   = 32'he0000003;
  localparam logic [31:0] OLD_JUMP_MATCH  = 32'h20000000;
  localparam logic [31:0] OLD_JUMP_TARGET = 32'h1fffffff;
  localparam logic [31:0] ALIGN_MASK      = 32'hfffffffc;
  localparam logic [31:0] RETURN_WORD     = 32'h00020000;
  localparam logic [31:0] HDR_MASK        = 32'he0030003;
  localparam logic [31:0] NINC_HDR_MATCH  = 32'h40000000;
  localparam logic [31:0] WORD_STEP       = 32'd4;

  // One classified request as it travels from front to back
  typedef struct packed {
    logic [31:0] word;
    logic [31:0] addr;
    logic [31:0] after;
    logic [2:0]  cls;
    logic        prot;
  } pbcd_item_t;

endpackage

[hdl/pbcd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pushbuffer decoder front
// Accepts fetched words, classifies the command, checks the buffer bound
// and holds the classified request for the queue.
// ----------------------------------------------------------------------------
module pbcd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_fetch_word,
  input  logic [31:0]         in_fetch_address,
  input  logic                cfg_write_enable,
  input  logic [31:0]         cfg_write_data,
  output logic                fr_valid,
  output pbcd_pkg::pbcd_item_t fr_item,
  input  logic                fr_take
);
  import pbcd_pkg::*;

  logic [31:0] buffer_length_r;
  logic        fr_valid_r;
  pbcd_item_t  fr_item_r;
  pbcd_item_t  item_nxt;
  logic        accept;

  // Classify one word as a command
  function automatic logic [2:0] classify(input logic [31:0] w);
    logic [2:0] c;
    if ((w & OLD_JUMP_MASK) == OLD_JUMP_MATCH) begin
      c = CLS_OLD_JUMP;
    end else if (w[1:0] == 2'd1) begin
      c = CLS_JUMP;
    end else if (w[1:0] == 2'd2) begin
      c = CLS_CALL;
    end else if (w == RETURN_WORD) begin
      c = CLS_RETURN;
    end else if ((w & HDR_MASK) == 32'd0) begin
      c = CLS_INC_HDR;
    end else if ((w & HDR_MASK) == NINC_HDR_MATCH) begin
      c = CLS_NINC_HDR;
    end else begin
      c = CLS_RESERVED;
    end
    return c;
  endfunction

  // Hold the input while the staged request cannot move on
  assign in_stall = fr_valid_r && !fr_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    item_nxt.word  = in_fetch_word;
    item_nxt.addr  = in_fetch_address;
    item_nxt.after = in_fetch_address + WORD_STEP;
    item_nxt.cls   = classify(in_fetch_word);
    item_nxt.prot  = (in_fetch_address >= buffer_length_r);
  end

  // Buffer length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_length_r <= '1;
    end else if (cfg_write_enable) begin
      buffer_length_r <= cfg_write_data;
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (!in_stall) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= item_nxt;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_item  = fr_item_r;

endmodule

[hdl/pbcd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pushbuffer decoder request queue
// Small register FIFO that lets front and back stall on their own.
// ----------------------------------------------------------------------------
module pbcd_queue #(
  parameter int Depth = pbcd_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_take,
  input  pbcd_pkg::pbcd_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_take,
  output pbcd_pkg::pbcd_item_t pop_item
);
  import pbcd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pbcd_item_t      mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            push, pop;

  assign push_take = push_valid && (count_r != FullCnt);
  assign push      = push_take;
  assign pop       = pop_take;
  assign pop_valid = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Fill count stays within depth and pops only come from a non-empty queue
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");

endmodule

[hdl/pbcd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pushbuffer decoder back
// Executes classified requests against the run, call and error state and
// registers one result per request.
// ----------------------------------------------------------------------------
module pbcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_take,
  input  pbcd_pkg::pbcd_item_t q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_method_valid,
  output logic [10:0]          out_method_word_address,
  output logic [2:0]           out_method_subch,
  output logic                 out_method_non_increasing,
  output logic [31:0]          out_method_data,
  output logic [31:0]          out_next_address,
  output logic [2:0]           out_error_code,
  output logic                 out_suspended
);
  import pbcd_pkg::*;

  // Run and call state
  logic [10:0] run_addr_r, run_addr_nxt;
  logic [2:0]  run_sub_r, run_sub_nxt;
  logic [10:0] run_count_r, run_count_nxt;
  logic        run_ni_r, run_ni_nxt;
  logic [31:0] ret_addr_r, ret_addr_nxt;
  logic        in_sub_r, in_sub_nxt;
  logic [2:0]  sticky_r, sticky_nxt;

  // Result register
  logic        out_valid_r;
  logic        m_valid_r, m_valid_nxt;
  logic [10:0] m_addr_r, m_addr_nxt;
  logic [2:0]  m_sub_r, m_sub_nxt;
  logic        m_ni_r, m_ni_nxt;
  logic [31:0] m_data_r, m_data_nxt;
  logic [31:0] next_r, next_nxt;

  logic take;

  assign take   = q_valid && (!out_valid_r || !out_stall);
  assign q_take = take;

  // Execute one request
  always_comb begin
    run_addr_nxt  = run_addr_r;
    run_sub_nxt   = run_sub_r;
    run_count_nxt = run_count_r;
    run_ni_nxt    = run_ni_r;
    ret_addr_nxt  = ret_addr_r;
    in_sub_nxt    = in_sub_r;
    sticky_nxt    = sticky_r;
    m_valid_nxt   = 1'b0;
    m_addr_nxt    = '0;
    m_sub_nxt     = '0;
    m_ni_nxt      = 1'b0;
    m_data_nxt    = '0;
    next_nxt      = q_item.addr;
    if (sticky_r != ERR_NONE) begin
      next_nxt = q_item.addr;
    end else if (q_item.prot) begin
      sticky_nxt = ERR_PROTECTION;
    end else if (run_count_r != '0) begin
      m_valid_nxt   = 1'b1;
      m_addr_nxt    = run_addr_r;
      m_sub_nxt     = run_sub_r;
      m_ni_nxt      = run_ni_r;
      m_data_nxt    = q_item.word;
      run_addr_nxt  = run_ni_r ? run_addr_r : run_addr_r + 1'b1;
      run_count_nxt = run_count_r - 1'b1;
      next_nxt      = q_item.after;
    end else begin
      case (q_item.cls)
        CLS_OLD_JUMP: begin
          next_nxt = q_item.word & OLD_JUMP_TARGET;
        end
        CLS_JUMP: begin
          next_nxt = q_item.word & ALIGN_MASK;
        end
        CLS_CALL: begin
          if (in_sub_r) begin
            sticky_nxt = ERR_CALL;
          end else begin
            ret_addr_nxt = q_item.after;
            in_sub_nxt   = 1'b1;
            next_nxt     = q_item.word & ALIGN_MASK;
          end
        end
        CLS_RETURN: begin
          if (!in_sub_r) begin
            sticky_nxt = ERR_RETURN;
            next_nxt   = q_item.after;
          end else begin
            next_nxt   = ret_addr_r & ALIGN_MASK;
            in_sub_nxt = 1'b0;
          end
        end
        CLS_INC_HDR, CLS_NINC_HDR: begin
          run_addr_nxt  = q_item.word[12:2];
          run_sub_nxt   = q_item.word[15:13];
          run_count_nxt = q_item.word[28:18];
          run_ni_nxt    = (q_item.cls == CLS_NINC_HDR);
          next_nxt      = q_item.after;
        end
        default: begin
          sticky_nxt = ERR_RESERVED;
          next_nxt   = q_item.after;
        end
      endcase
    end
  end

  // Update state on each taken request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_addr_r  <= '0;
      run_sub_r   <= '0;
      run_count_r <= '0;
      run_ni_r    <= 1'b0;
      ret_addr_r  <= '0;
      in_sub_r    <= 1'b0;
      sticky_r    <= ERR_NONE;
    end else if (take) begin
      run_addr_r  <= run_addr_nxt;
      run_sub_r   <= run_sub_nxt;
      run_count_r <= run_count_nxt;
      run_ni_r    <= run_ni_nxt;
      ret_addr_r  <= ret_addr_nxt;
      in_sub_r    <= in_sub_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (take) begin
      m_valid_r <= m_valid_nxt;
      m_addr_r  <= m_addr_nxt;
      m_sub_r   <= m_sub_nxt;
      m_ni_r    <= m_ni_nxt;
      m_data_r  <= m_data_nxt;
      next_r    <= next_nxt;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_method_valid          = m_valid_r;
  assign out_method_word_address   = m_addr_r;
  assign out_method_subch          = m_sub_r;
  assign out_method_non_increasing = m_ni_r;
  assign out_method_data           = m_data_r;
  assign out_next_address          = next_r;
  assign out_error_code            = sticky_r;
  assign out_suspended             = (sticky_r != ERR_NONE);

  // An error, once raised, holds until reset
  a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (sticky_r != ERR_NONE) |=> (sticky_r == $past(sticky_r)))
    else $error("sticky error changed");

  // Dispatching method data drops the run count by one
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    (take && sticky_r == ERR_NONE && !q_item.prot && run_count_r != '0)
      |=> (run_count_r == $past(run_count_r) - 11'd1))
    else $error("run count did not drop");

  // A dispatched data word never carries an error
  a_data_no_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && m_valid_r) |-> (sticky_r == ERR_NONE))
    else $error("method data with error");

endmodule

[hdl/pushbuffer_command_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pushbuffer command decoder
// Top level: classify front, request queue and execute back.
// ----------------------------------------------------------------------------
// The decoder takes one pushbuffer word and its byte address per cycle while
// in_stall is low and returns exactly one result per word, in order: either
// method data for the active run, or the outcome of a command, always with
// the next fetch address and the sticky error state. A word accepted by the
// front passes the front stage register, a queue entry and the result
// register, in that order; sustained rate is one word per cycle while nothing
// stalls, as the back updates its state on each taken request. The front
// classifies and bound-checks each word; while a result waits on out_stall,
// the front stage and the queue of QueueDepth entries take up to
// QueueDepth + 1 further words before in_stall rises.
// Write buffer_length only while the decoder is idle. Once an error is raised
// the decoder reports it and ignores further words until reset.
module pushbuffer_command_decoder #(
  parameter int QueueDepth = pbcd_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_fetch_word,
  input  logic [31:0] in_fetch_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_method_valid,
  output logic [10:0] out_method_word_address,
  output logic [2:0]  out_method_subch,
  output logic        out_method_non_increasing,
  output logic [31:0] out_method_data,
  output logic [31:0] out_next_address,
  output logic [2:0]  out_error_code,
  output logic        out_suspended,
  input  logic        cfg_write_enable,
  input  logic [31:0] cfg_write_data
);
  import pbcd_pkg::*;

  logic       fr_valid, fr_take;
  pbcd_item_t fr_item;
  logic       q_valid, q_take;
  pbcd_item_t q_item;

  // Classify front
  pbcd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_fetch_word    (in_fetch_word),
    .in_fetch_address (in_fetch_address),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .fr_valid         (fr_valid),
    .fr_item          (fr_item),
    .fr_take          (fr_take)
  );

  // Request queue
  pbcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_take  (fr_take),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_take   (q_take),
    .pop_item   (q_item)
  );

  // Execute back
  pbcd_back u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .q_valid                   (q_valid),
    .q_take                    (q_take),
    .q_item                    (q_item),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_method_valid          (out_method_valid),
    .out_method_word_address   (out_method_word_address),
    .out_method_subch          (out_method_subch),
    .out_method_non_increasing (out_method_non_increasing),
    .out_method_data           (out_method_data),
    .out_next_address          (out_next_address),
    .out_error_code            (out_error_code),
    .out_suspended             (out_suspended)
  );

endmodule
